[sv/elrf_pkg.sv]
package elrf_pkg;

  localparam int unsigned IdWidth  = 32;
  localparam int unsigned NumCells = 64;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_EDGE  = 2'd2
  } op_e;

  typedef logic [IdWidth-1:0] id_t;

  // request travelling down the cell chain
  typedef struct packed {
    logic        valid;
    op_e         op;
    id_t         id;
    logic [31:0] row;
    logic [31:0] col;
    logic        hit;     // id matched a stored entry
    logic        stored;  // load already placed in a cell
  } tok_t;

endpackage

[sv/elrf_cell.sv]
module elrf_cell import elrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic valid_q, valid_d;
  id_t  id_q;
  tok_t tok_q, tok_d;
  logic hit_here;
  logic store;

  assign hit_here = valid_q && (tok_i.id == id_q);
  assign store    = tok_i.valid && (tok_i.op == OP_LOAD) && !valid_q &&
                    !tok_i.hit && !tok_i.stored;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    if (tok_i.valid) begin
      unique case (tok_i.op)
        OP_LOAD: begin
          tok_d.hit    = tok_i.hit | hit_here;
          tok_d.stored = tok_i.stored | store;
          if (store) begin
            valid_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          valid_d = 1'b0;
        end
        OP_EDGE: begin
          tok_d.hit = tok_i.hit | hit_here;
        end
        default: begin
          tok_d.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      id_q <= tok_i.id;
    end
  end

  assign tok_o = tok_q;

endmodule

[sv/edge_list_removal_filter.sv]
// Edge list removal filter. Takes one request per clock (busy_o never rises).
// A kept edge reaches the receiver after its request is accepted and
// walks NumCells = 64 cell registers, one stored removal id per cell, and
// then one output register. Results appear on out_valid_o for one cycle
// and cannot be stalled. Loads, clears and unused opcodes give no result.
// explicit_ids is set by a cfg handshake and used when an edge is accepted.
module edge_list_removal_filter import elrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] item_id_i,
  input  logic [31:0] row_i,
  input  logic [31:0] col_i,
  input  logic        last_edge_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_explicit_ids_i,
  output logic        out_valid_o,
  output logic [31:0] out_row_o,
  output logic [31:0] out_col_o,
  output logic [31:0] out_edge_id_o,
  output logic        set_overflow_o
);

  logic explicit_q;
  id_t  pos_q, pos_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  logic [31:0] out_row_q, out_col_q, out_id_q;
  logic out_ovf_q;
  logic accept;
  tok_t head;
  tok_t chain [NumCells];
  tok_t tail;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_comb begin
    head        = '0;
    head.row    = row_i;
    head.col    = col_i;
    head.id     = item_id_i;
    head.op     = OP_LOAD;
    pos_d       = pos_q;
    unique case (opcode_i)
      OP_LOAD: begin
        head.valid = accept;
      end
      OP_CLEAR: begin
        head.valid = accept;
        head.op    = OP_CLEAR;
      end
      OP_EDGE: begin
        head.valid = accept;
        head.op    = OP_EDGE;
        if (!explicit_q) begin
          head.id = pos_q;
        end
        if (accept) begin
          pos_d = last_edge_i ? '0 : pos_q + id_t'(1);
        end
      end
      default: begin
        head.valid = 1'b0;
      end
    endcase
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == 0) begin : g_first
      elrf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .tok_i  (head),
        .tok_o  (chain[k])
      );
    end else begin : g_next
      elrf_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .tok_i  (chain[k-1]),
        .tok_o  (chain[k])
      );
    end
  end

  assign tail = chain[NumCells-1];

  always_comb begin
    ovf_d       = ovf_q;
    out_valid_d = 1'b0;
    if (tail.valid && tail.op == OP_LOAD && !tail.hit && !tail.stored) begin
      ovf_d = 1'b1;
    end
    if (tail.valid && tail.op == OP_EDGE && !tail.hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      explicit_q  <= 1'b0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        explicit_q <= cfg_explicit_ids_i;
      end
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d) begin
      out_row_q <= tail.row;
      out_col_q <= tail.col;
      out_id_q  <= tail.id;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign out_edge_id_o  = out_id_q;
  assign set_overflow_o = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_ovf_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ovf_q))
    else $error("overflow flag dropped");

  a_out_from_kept_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d |-> (tail.valid && tail.op == OP_EDGE && !tail.hit))
    else $error("result without a kept edge");

  a_load_hit_or_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail.valid && tail.op == OP_LOAD) |-> !(tail.hit && tail.stored))
    else $error("load both matched and stored");

  a_out_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_d |=> out_valid_o)
    else $error("kept edge not presented");
`endif

endmodule
